// ----- hw/rtl/pjq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjq_pkg: shared types for the priority job queue
// Command codes, transfer payloads, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pjq_pkg;

  localparam int unsigned ProvFieldW  = 8;
  localparam int unsigned PrioFieldW  = 8;
  localparam int unsigned CountFieldW = 7;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TAKE   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                   command;
    logic [ProvFieldW-1:0]  provider_id;
    logic [PrioFieldW-1:0]  job_priority;
    logic [CountFieldW-1:0] job_count;
  } pjq_in_t;

  typedef struct packed {
    logic [ProvFieldW-1:0]  taken_provider;
    logic                   taken_valid;
    logic [CountFieldW-1:0] removed_count;
    logic [CountFieldW-1:0] dropped_count;
    logic [CountFieldW-1:0] occupancy;
  } pjq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FILL,
    ST_COMPACT,
    ST_REPLY
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the accepted item
    logic shift;    // add: scan down from the tail, moving entries up
    logic fill;     // add: write one new copy
    logic compact;  // cancel/take: read-filter-write pass
    logic commit;   // cancel/take: new count from the write pointer
    logic publish;  // load the output register
  } pjq_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic add_none;      // add would insert nothing
    logic shift_done;
    logic fill_last;
    logic compact_done;
  } pjq_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pjq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjq_datapath: entry store, cursors and result registers
// One-write/one-read entry memory with registered read data; a one-deep
// read pipeline feeds the shift and compact passes.
// ----------------------------------------------------------------------------
module pjq_datapath import pjq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PROVIDER_BITS = 8,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pjq_in_t   in_data_i,
  input  wire pjq_ctrl_t ctrl_i,
  output pjq_stat_t      stat_o,
  output pjq_out_t       out_data_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned WW = (CW > CountFieldW) ? CW : CountFieldW;
  localparam int unsigned EW = PROVIDER_BITS + PRIORITY_BITS;
  localparam logic [WW-1:0] DepthW = WW'(QUEUE_DEPTH);

  // entry store: {provider, priority}
  logic [EW-1:0] mem_q [QUEUE_DEPTH];
  logic [EW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  // control registers
  logic [CW-1:0] cnt_q, rd_q, wr_q;
  logic          pv_q;
  // item and cursor payload
  cmd_e               op_q;
  logic [PROVIDER_BITS-1:0] prov_q, taken_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [CW-1:0]      ins_q, fp_q, pa_q;
  logic [CountFieldW-1:0] drop_q;
  logic [WW-1:0]      rem_q;
  logic               tvalid_q;
  pjq_out_t           out_q;

  // input fields cut to the configured widths
  logic [PROVIDER_BITS+ProvFieldW-1:0] prov_pad;
  logic [PRIORITY_BITS+PrioFieldW-1:0] prio_pad;
  logic [PROVIDER_BITS-1:0] in_prov;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [PROVIDER_BITS+ProvFieldW-1:0] taken_pad;

  logic [WW-1:0] want, room, ins_w, drop_w, cnt_w;
  logic [CW-1:0] rd_m1;
  logic [PROVIDER_BITS-1:0] rd_prov;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic hit, drop_e, issue_shift, issue_comp;

  assign prov_pad  = {{PROVIDER_BITS{1'b0}}, in_data_i.provider_id};
  assign prio_pad  = {{PRIORITY_BITS{1'b0}}, in_data_i.job_priority};
  assign in_prov   = prov_pad[PROVIDER_BITS-1:0];
  assign in_prio   = prio_pad[PRIORITY_BITS-1:0];
  assign taken_pad = {{ProvFieldW{1'b0}}, taken_q};

  // copies that fit
  assign want   = WW'(in_data_i.job_count);
  assign room   = DepthW - WW'(cnt_q);
  assign ins_w  = (want < room) ? want : room;
  assign drop_w = want - ins_w;
  assign cnt_w  = WW'(cnt_q);

  assign rd_m1   = rd_q - CW'(1);
  assign rd_prov = rdata_q[EW-1:PRIORITY_BITS];
  assign rd_prio = rdata_q[PRIORITY_BITS-1:0];

  // add scan stops at the first entry (from the tail) not below the new one
  assign hit    = pv_q && (rd_prio >= prio_q);
  assign drop_e = ((op_q == CMD_CANCEL) && (rd_prov == prov_q)) ||
                  ((op_q == CMD_TAKE) && (pa_q == '0));
  assign issue_shift = ctrl_i.shift && !hit && (rd_q != '0);
  assign issue_comp  = ctrl_i.compact && (rd_q != cnt_q);

  always_comb begin
    raddr = ctrl_i.shift ? rd_m1[AW-1:0] : rd_q[AW-1:0];
    we    = 1'b0;
    waddr = wr_q[AW-1:0];
    wdata = rdata_q;
    if (ctrl_i.shift) begin
      we    = pv_q && !hit;
      waddr = AW'(pa_q + ins_q);
    end else if (ctrl_i.fill) begin
      we    = 1'b1;
      waddr = fp_q[AW-1:0];
      wdata = {prov_q, prio_q};
    end else if (ctrl_i.compact) begin
      we    = pv_q && !drop_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
      pv_q  <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        rd_q <= (in_data_i.command == CMD_ADD) ? cnt_q : '0;
        wr_q <= '0;
        pv_q <= 1'b0;
      end
      if (ctrl_i.shift) begin
        pv_q <= issue_shift;
        if (issue_shift) begin
          rd_q <= rd_m1;
        end
      end
      if (ctrl_i.fill) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (ctrl_i.compact) begin
        pv_q <= issue_comp;
        if (issue_comp) begin
          rd_q <= rd_q + CW'(1);
        end
        if (pv_q && !drop_e) begin
          wr_q <= wr_q + CW'(1);
        end
      end
      if (ctrl_i.commit) begin
        cnt_q <= wr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q     <= in_data_i.command;
      prov_q   <= in_prov;
      prio_q   <= in_prio;
      ins_q    <= ins_w[CW-1:0];
      drop_q   <= (in_data_i.command == CMD_ADD) ? drop_w[CountFieldW-1:0] : '0;
      fp_q     <= cnt_q;
      rem_q    <= '0;
      tvalid_q <= 1'b0;
      taken_q  <= '0;
    end
    if (ctrl_i.shift) begin
      if (issue_shift) begin
        pa_q <= rd_m1;
      end
      // lowest moved entry marks the insertion point
      if (pv_q && !hit) begin
        fp_q <= pa_q;
      end
    end
    if (ctrl_i.fill) begin
      fp_q  <= fp_q + CW'(1);
      ins_q <= ins_q - CW'(1);
    end
    if (ctrl_i.compact) begin
      if (issue_comp) begin
        pa_q <= rd_q;
      end
      if (pv_q && (op_q == CMD_TAKE) && (pa_q == '0)) begin
        tvalid_q <= 1'b1;
        taken_q  <= rd_prov;
      end
    end
    if (ctrl_i.commit && (op_q == CMD_CANCEL)) begin
      rem_q <= cnt_w - WW'(wr_q);
    end
    if (ctrl_i.publish) begin
      out_q.taken_provider <= taken_pad[ProvFieldW-1:0];
      out_q.taken_valid    <= tvalid_q;
      out_q.removed_count  <= rem_q[CountFieldW-1:0];
      out_q.dropped_count  <= drop_q;
      out_q.occupancy      <= cnt_w[CountFieldW-1:0];
    end
  end

  assign stat_o.add_none     = (ins_w == '0);
  assign stat_o.shift_done   = hit || ((rd_q == '0) && !pv_q);
  assign stat_o.fill_last    = (ins_q == CW'(1));
  assign stat_o.compact_done = (rd_q == cnt_q) && !pv_q;

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/pjq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pjq_ctrl: sequencing state machine
// Accepts one item at a time, steps the datapath passes and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module pjq_ctrl import pjq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire cmd_e      in_cmd_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire pjq_stat_t stat_i,
  output pjq_ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.load = 1'b1;
          unique case (in_cmd_i)
            CMD_ADD:    state_d = stat_i.add_none ? ST_REPLY : ST_SHIFT;
            CMD_CANCEL: state_d = ST_COMPACT;
            CMD_TAKE:   state_d = ST_COMPACT;
            CMD_NOP:    state_d = ST_REPLY;
            default:    state_d = ST_REPLY;
          endcase
        end
      end
      ST_SHIFT: begin
        ctrl_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        ctrl_o.fill = 1'b1;
        if (stat_i.fill_last) begin
          state_d = ST_REPLY;
        end
      end
      ST_COMPACT: begin
        ctrl_o.compact = 1'b1;
        if (stat_i.compact_done) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          ctrl_o.publish = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- hw/rtl/priority_job_queue_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item at a time; the entry memory's single read and write
//   port moves one entry per cycle.
// Reset: queue empties at once (count cleared); entry memory is not cleared.
// ----------------------------------------------------------------------------
// priority_job_queue_top: stable priority job queue with cancel
// Entries are held in non-increasing priority order, equal priorities in
// arrival order. Add moves lower-priority entries up from the tail and then
// writes the new copies; cancel and take run one compaction pass that drops
// matching entries (cancel) or the head entry (take).
// ----------------------------------------------------------------------------
module priority_job_queue_top import pjq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PROVIDER_BITS = 8,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  // input channel: one transfer per command
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire pjq_in_t in_data_i,
  // result channel: one transfer per command
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pjq_out_t     out_data_o
);

  pjq_ctrl_t ctrl;
  pjq_stat_t stat;

  // Controller: sequencing only. It holds the output valid flag so a
  // finished result can wait in the output register while the next
  // command is already being worked on.
  pjq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Datapath: entry memory, occupancy count, scan cursors and the
  // output payload register.
  pjq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PROVIDER_BITS (PROVIDER_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
